// File: rtl/srmac_pkg.sv
// shared constants, codes and control structs for the sparse row mac block
// no dependencies; used through scoped names by every rtl file but srmac_ram
`default_nettype none

package srmac_pkg;

   // defaults for the top level parameters
   localparam int VECTOR_DEPTH_DEF = 4096;
   localparam int FRAC_BITS_DEF    = 16;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 12;
   localparam int SAMPLE_W = 32;
   localparam int WEIGHT_W = 18;
   localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
   localparam int SUM_W    = 56;

   // result queue
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W     = $clog2(RSP_FIFO_DEPTH);
   localparam int FIFO_CNT_W     = $clog2(RSP_FIFO_DEPTH + 1);

   // op codes
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
   localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;

   // saturation limits and start values of the row min/max trackers
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // control carried along the row pipeline
   typedef struct packed {
      logic valid;
      logic empty;
      logic last;
   } stage_ctl_type;

   // which accumulator stages hold an item that will produce a result
   typedef struct packed {
      logic s2_result;
      logic s3_result;
   } acc_status_type;

endpackage

`default_nettype wire

// File: rtl/srmac_ram.sv
// generic single-clock ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module srmac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/srmac_rowacc.sv
// row datapath: multiply stage, saturating accumulate with min/max, clamp
// depends on srmac_pkg
`default_nettype none

module srmac_rowacc #(
   parameter int FRAC_BITS = srmac_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire srmac_pkg::stage_ctl_type               s1_ctl,
   input  wire logic signed [srmac_pkg::SAMPLE_W-1:0]  s1_sample,
   input  wire logic signed [srmac_pkg::WEIGHT_W-1:0]  s1_weight,
   output srmac_pkg::acc_status_type                   status,
   output logic                                        res_valid,
   output logic signed [srmac_pkg::SAMPLE_W-1:0]       res_value
);

   localparam int SW = srmac_pkg::SAMPLE_W;
   localparam int PW = srmac_pkg::PROD_W;
   localparam int UW = srmac_pkg::SUM_W;

   // product stage
   srmac_pkg::stage_ctl_type s2_ctl_ff, s2_ctl_in;
   logic signed [PW-1:0] s2_prod_ff, s2_prod_in;
   logic signed [SW-1:0] s2_sample_ff;

   // running row state
   logic signed [UW-1:0] sum_ff, sum_in;
   logic signed [SW-1:0] min_ff, min_in;
   logic signed [SW-1:0] max_ff, max_in;

   // finished row stage
   logic                 s3_valid_ff, s3_valid_in;
   logic                 s3_empty_ff;
   logic signed [UW-1:0] s3_sum_ff;
   logic signed [SW-1:0] s3_min_ff;
   logic signed [SW-1:0] s3_max_ff;

   logic signed [UW:0]   sum_wide;
   logic signed [UW-1:0] sum_sat;
   logic signed [SW-1:0] min_new, max_new;
   logic signed [UW-1:0] shifted;
   logic signed [SW-1:0] clamped;
   logic                 row_done;

   assign s2_ctl_in  = s1_ctl;
   assign s2_prod_in = PW'(s1_weight) * PW'(s1_sample);

   always_comb begin
      sum_wide = (UW+1)'(sum_ff) + (UW+1)'(s2_prod_ff);
      if (sum_wide[UW] != sum_wide[UW-1]) begin
         sum_sat = sum_wide[UW] ? srmac_pkg::SUM_MIN : srmac_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[UW-1:0];
      end
      min_new = (s2_sample_ff < min_ff) ? s2_sample_ff : min_ff;
      max_new = (s2_sample_ff > max_ff) ? s2_sample_ff : max_ff;
   end

   assign row_done    = s2_ctl_ff.valid && (s2_ctl_ff.empty || s2_ctl_ff.last);
   assign s3_valid_in = row_done;

   // an empty row or the last nonzero hands the row off and restarts it
   always_comb begin
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (row_done) begin
         sum_in = '0;
         min_in = srmac_pkg::SAMPLE_MAX;
         max_in = srmac_pkg::SAMPLE_MIN;
      end else if (s2_ctl_ff.valid) begin
         sum_in = sum_sat;
         min_in = min_new;
         max_in = max_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff   <= '0;
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
         min_ff      <= srmac_pkg::SAMPLE_MAX;
         max_ff      <= srmac_pkg::SAMPLE_MIN;
      end else begin
         s2_ctl_ff   <= s2_ctl_in;
         s3_valid_ff <= s3_valid_in;
         sum_ff      <= sum_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_prod_ff   <= s2_prod_in;
      s2_sample_ff <= s1_sample;
      s3_empty_ff  <= s2_ctl_ff.empty;
      s3_sum_ff    <= sum_sat;
      s3_min_ff    <= min_new;
      s3_max_ff    <= max_new;
   end

   // floor shift, then clamp into the row's sample range
   always_comb begin
      shifted = s3_sum_ff >>> FRAC_BITS;
      if (shifted < UW'(s3_min_ff)) begin
         clamped = s3_min_ff;
      end else if (shifted > UW'(s3_max_ff)) begin
         clamped = s3_max_ff;
      end else begin
         clamped = shifted[SW-1:0];
      end
   end

   assign res_valid        = s3_valid_ff;
   assign res_value        = s3_empty_ff ? '0 : clamped;
   assign status.s2_result = row_done;
   assign status.s3_result = s3_valid_ff;

endmodule

`default_nettype wire

// File: rtl/sparse_row_mac_with_clamp.sv
// top level of the sparse row multiply-accumulate with per-row clamp
// depends on srmac_pkg, srmac_ram and srmac_rowacc
`default_nettype none

// Streams a sparse matrix in row order against a vector held in an on-chip
// ram of VECTOR_DEPTH 32-bit samples. A load transfer writes one sample; a
// nonzero transfer reads the sample at its column and adds weight times
// sample into a saturating 56-bit sum while tracking the row's sample
// minimum and maximum; the nonzero flagged row_end emits the sum shifted
// right by FRAC_BITS (floor) and clamped to that range. An empty-row
// transfer emits zero and drops any partial row. One item is taken per
// cycle while req_ready is high; the rate is set by the accumulate loop,
// fed by one ram read per nonzero. A result passes the ram read, multiply,
// accumulate and clamp steps, then waits in an 8-entry result queue that
// offers it on rsp_valid; req_ready drops only when that queue together
// with the results still in the pipeline would fill it. Samples must be
// loaded before they are read: the ram has no clear after reset. A load
// takes effect for any nonzero accepted in the next cycle or later.

module sparse_row_mac_with_clamp #(
   parameter int VECTOR_DEPTH = srmac_pkg::VECTOR_DEPTH_DEF,
   parameter int FRAC_BITS    = srmac_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [srmac_pkg::OP_W-1:0]             req_op,
   input  wire logic [srmac_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [srmac_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic signed [srmac_pkg::WEIGHT_W-1:0]  req_weight,
   input  wire logic                                   req_row_end,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [srmac_pkg::SAMPLE_W-1:0]       rsp_row_value
);

   localparam int AW  = $clog2(VECTOR_DEPTH);
   localparam int XW  = AW + srmac_pkg::POS_W;
   localparam int SW  = srmac_pkg::SAMPLE_W;
   localparam int CW  = srmac_pkg::FIFO_CNT_W;
   localparam int PTW = srmac_pkg::FIFO_PTR_W;

   logic          req_xfer;
   logic          rsp_xfer;
   logic [XW-1:0] pos_ext;
   logic [AW-1:0] ram_addr;
   logic          pos_in_range;
   logic          ram_wr_en;
   logic [SW-1:0] ram_rd_data;

   // read stage: waits for the ram read
   srmac_pkg::stage_ctl_type s1_ctl_ff, s1_ctl_in;
   logic                     s1_in_range_ff;
   logic signed [srmac_pkg::WEIGHT_W-1:0] s1_weight_ff;
   logic signed [SW-1:0]     s1_sample;

   srmac_pkg::acc_status_type acc_status;
   logic                      res_valid;
   logic signed [SW-1:0]      res_value;

   // result queue
   logic [SW-1:0]  fifo_mem_ff [srmac_pkg::RSP_FIFO_DEPTH];
   logic [PTW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pending;
   logic           s1_result;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // positions past the end of the store are never written and read as zero
   assign pos_ext      = XW'(req_position);
   assign ram_addr     = pos_ext[AW-1:0];
   assign pos_in_range = pos_ext < XW'(VECTOR_DEPTH);
   assign ram_wr_en    = req_xfer && (req_op == srmac_pkg::OP_LOAD) && pos_in_range;

   srmac_ram #(
      .WIDTH (SW),
      .DEPTH (VECTOR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_sample),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_ctl_in.valid = req_xfer &&
                        ((req_op == srmac_pkg::OP_NONZERO) || (req_op == srmac_pkg::OP_EMPTY));
      s1_ctl_in.empty = req_op == srmac_pkg::OP_EMPTY;
      s1_ctl_in.last  = req_row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_in_range_ff <= pos_in_range;
      s1_weight_ff   <= req_weight;
   end

   assign s1_sample = s1_in_range_ff ? ram_rd_data : '0;

   srmac_rowacc #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rowacc (
      .clock     (clock),
      .reset     (reset),
      .s1_ctl    (s1_ctl_ff),
      .s1_sample (s1_sample),
      .s1_weight (s1_weight_ff),
      .status    (acc_status),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   // credit check: every result in flight already owns a queue slot
   assign s1_result = s1_ctl_ff.valid && (s1_ctl_ff.empty || s1_ctl_ff.last);
   assign pending   = CW'(s1_result) + CW'(acc_status.s2_result) + CW'(acc_status.s3_result);
   assign req_ready = (count_ff + pending) < CW'(srmac_pkg::RSP_FIFO_DEPTH);

   always_comb begin
      wr_ptr_in = res_valid ? wr_ptr_ff + PTW'(1) : wr_ptr_ff;
      rd_ptr_in = rsp_xfer ? rd_ptr_ff + PTW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(res_valid) - CW'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         fifo_mem_ff[wr_ptr_ff] <= res_value;
      end
   end

   assign rsp_valid     = count_ff != '0;
   assign rsp_row_value = fifo_mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/srmac_checker.sv
// port-level checks for the sparse row mac top level, with its bind
// depends on srmac_pkg and sparse_row_mac_with_clamp
`default_nettype none

module srmac_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic [srmac_pkg::OP_W-1:0]            req_op,
   input wire logic                                  req_row_end,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [srmac_pkg::SAMPLE_W-1:0] rsp_row_value
);

   localparam int CW = srmac_pkg::FIFO_CNT_W;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          makes_result;
   logic [CW-1:0] owed_ff, owed_in;

   assign req_xfer     = req_valid && req_ready;
   assign rsp_xfer     = rsp_valid && rsp_ready;
   assign makes_result = (req_op == srmac_pkg::OP_EMPTY) ||
                         ((req_op == srmac_pkg::OP_NONZERO) && req_row_end);

   // results accepted on the request side but not yet delivered
   assign owed_in = owed_ff + CW'(req_xfer && makes_result) - CW'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_value_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_row_value))
      else $error("rsp_row_value changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != '0)
      else $error("result offered with nothing owed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      owed_ff == '0 |-> req_ready)
      else $error("request side stalled with nothing owed");

   a_empty_row_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_op == srmac_pkg::OP_EMPTY) && (owed_ff == '0) |-> ##4 rsp_valid)
      else $error("empty row result late");

endmodule

bind sparse_row_mac_with_clamp srmac_checker u_srmac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_op        (req_op),
   .req_row_end   (req_row_end),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_row_value (rsp_row_value)
);

`default_nettype wire
